// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the decryptor.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define CCSD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("decryptor checker: property failed");

// Check a property on every rising edge, reset included.
`define CCSD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("decryptor checker: property failed");

`endif

// ----- rtl/ccsd_pkg.sv -----
// Shared types, constants and AES helper functions of the CCM* CTR decryptor.
// No dependencies.
package ccsd_pkg;

  localparam logic [3:0] NonceMin    = 4'd7;
  localparam logic [3:0] NonceMax    = 4'd13;
  localparam logic [3:0] BlockTop    = 4'd15;
  localparam logic [3:0] NonceLenRst = 4'd13;
  localparam logic [7:0] ByteMask    = 8'hff;

  typedef enum logic [2:0] {
    REG_KEY_HIGH    = 3'd0,
    REG_KEY_LOW     = 3'd1,
    REG_NONCE_UPPER = 3'd2,
    REG_NONCE_LOWER = 3'd3,
    REG_NONCE_LEN   = 3'd4
  } ccsd_reg_e;

  // One queued byte with its classification.
  typedef struct packed {
    logic [7:0] cbyte;
    logic       fin;
    logic       bad;
    logic [3:0] pos;
    logic       first;
  } ccsd_entry_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Counter mask for a counter field of q bytes.
  function automatic logic [63:0] ctr_mask(input logic [3:0] q);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      m[8*b +: 8] = (4'(b) < q) ? ByteMask : 8'h00;
    end
    ctr_mask = m;
  endfunction

endpackage

// ----- rtl/ccsd_fifo.sv -----
// Small register queue used between the decryptor parts.
// No dependencies.
module ccsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             wr, rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr      = push_i & ~full_o;
  assign rd      = pop_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (wr) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + CW'(wr) - CW'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end
endmodule

// ----- rtl/ccsd_front.sv -----
// Front end: tracks block position and counter, classifies bytes, forms
// counter blocks for the AES unit. Depends on ccsd_pkg.
module ccsd_front
  import ccsd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    cipher_byte_i,
  input  logic          final_byte_i,
  input  logic [3:0]    nonce_length_i,
  input  logic [39:0]   nonce_upper_i,
  input  logic [63:0]   nonce_lower_i,
  output ccsd_entry_t   entry_o,
  output logic          req_push_o,
  output logic [127:0]  req_block_o
);
  logic [63:0]  ctr_q, ctr_d, ctr_m;
  logic [3:0]   pos_q, pos_d, pos_inc, q;
  logic         bad;
  logic [103:0] nonce;
  logic [127:0] blk;

  assign bad   = (nonce_length_i < NonceMin) || (nonce_length_i > NonceMax);
  assign q     = BlockTop - nonce_length_i;
  assign ctr_m = ctr_q & ctr_mask(q);
  assign nonce = {nonce_upper_i, nonce_lower_i};
  assign pos_inc = pos_q + 4'd1;

  // Flags byte, then nonce bytes, then the counter in the last q bytes.
  always_comb begin
    blk = '0;
    blk[127:120] = {4'd0, q - 4'd1};
    for (int i = 1; i < 14; i++) begin
      if (4'(i) <= nonce_length_i) begin
        blk[127-8*i -: 8] = nonce[111-8*i -: 8];
      end
    end
    for (int j = 0; j < 8; j++) begin
      if (4'(j) < q) begin
        blk[8*j +: 8] = ctr_m[8*j +: 8];
      end
    end
  end

  assign entry_o     = '{cbyte: cipher_byte_i, fin: final_byte_i, bad: bad,
                         pos: pos_q, first: (pos_q == 4'd0)};
  assign req_push_o  = accept_i & ~bad & (pos_q == 4'd0);
  assign req_block_o = blk;

  always_comb begin
    ctr_d = ctr_q;
    pos_d = pos_q;
    if (accept_i) begin
      if (!bad) begin
        pos_d = pos_inc;
        if (pos_inc == 4'd0) begin
          ctr_d = (ctr_q + 64'd1) & ctr_mask(q);
        end
      end
      if (final_byte_i) begin
        ctr_d = 64'd1;
        pos_d = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= 64'd1;
      pos_q <= 4'd0;
    end else begin
      ctr_q <= ctr_d;
      pos_q <= pos_d;
    end
  end
endmodule

// ----- rtl/ccsd_aes.sv -----
// Iterative AES-128 encryptor, one round per cycle with on-the-fly key
// expansion. Depends on ccsd_pkg.
module ccsd_aes
  import ccsd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [127:0]  block_i,
  input  logic [127:0]  key_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [127:0]  out_data_o
);
  logic [127:0] st_q, st_d, rk_q, rk_d, rk_nx, rnd;
  logic [7:0]   rc_q, rc_d;
  logic [3:0]   round_q, round_d;
  logic         busy_q, busy_d, done_q, done_d;
  logic [7:0]   t [16];
  logic [31:0]  tmp;

  assign in_ready_o  = ~busy_q & ~done_q;
  assign out_valid_o = done_q;
  assign out_data_o  = st_q;

  // Next round key.
  always_comb begin
    tmp = {SBOX[rk_q[23:16]] ^ rc_q, SBOX[rk_q[15:8]], SBOX[rk_q[7:0]], SBOX[rk_q[31:24]]};
    rk_nx[127:96] = rk_q[127:96] ^ tmp;
    rk_nx[95:64]  = rk_q[95:64] ^ rk_nx[127:96];
    rk_nx[63:32]  = rk_q[63:32] ^ rk_nx[95:64];
    rk_nx[31:0]   = rk_q[31:0] ^ rk_nx[63:32];
  end

  // SubBytes, ShiftRows, MixColumns (skipped in the last round); AddRoundKey is in the state update.
  always_comb begin
    logic [7:0] a0, a1, a2, a3, x;
    for (int i = 0; i < 16; i++) begin
      t[i] = SBOX[st_q[127-8*((i%4) + 4*(((i/4) + (i%4)) % 4)) -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      x  = a0 ^ a1 ^ a2 ^ a3;
      if (round_q != 4'd10) begin
        rnd[127-32*c -: 8] = a0 ^ x ^ xtime(a0 ^ a1);
        rnd[119-32*c -: 8] = a1 ^ x ^ xtime(a1 ^ a2);
        rnd[111-32*c -: 8] = a2 ^ x ^ xtime(a2 ^ a3);
        rnd[103-32*c -: 8] = a3 ^ x ^ xtime(a3 ^ a0);
      end else begin
        rnd[127-32*c -: 32] = {a0, a1, a2, a3};
      end
    end
  end

  always_comb begin
    st_d    = st_q;
    rk_d    = rk_q;
    rc_d    = rc_q;
    round_d = round_q;
    busy_d  = busy_q;
    done_d  = done_q;
    if (done_q && out_ready_i) begin
      done_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      st_d    = block_i ^ key_i;
      rk_d    = key_i;
      rc_d    = 8'h01;
      round_d = 4'd1;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      st_d    = rnd ^ rk_nx;
      rk_d    = rk_nx;
      rc_d    = xtime(rc_q);
      round_d = round_q + 4'd1;
      if (round_q == 4'd10) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      round_q <= 4'd0;
      rc_q    <= 8'h01;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      round_q <= round_d;
      rc_q    <= rc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    rk_q <= rk_d;
  end
endmodule

// ----- rtl/ccsd_back.sv -----
// Back end: pairs queued bytes with keystream blocks and holds the result
// register. Depends on ccsd_pkg.
module ccsd_back
  import ccsd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ccsd_entry_t   entry_i,
  input  logic          entry_empty_i,
  output logic          entry_pop_o,
  input  logic [127:0]  ks_i,
  input  logic          ks_empty_i,
  output logic          ks_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [7:0]    plain_byte_o,
  output logic          end_of_message_o,
  output logic          bad_nonce_length_o
);
  logic [127:0] cur_q, ks_use;
  logic         ov_q, ov_d, slot_free, need_ks, go;
  logic [7:0]   pb_q, pb_d;
  logic         eom_q, bad_q;

  assign slot_free = ~ov_q | pop_i;
  assign need_ks   = ~entry_i.bad & entry_i.first;
  assign go        = slot_free & ~entry_empty_i & (~need_ks | ~ks_empty_i);
  assign entry_pop_o = go;
  assign ks_pop_o    = go & need_ks;
  assign ks_use      = entry_i.first ? ks_i : cur_q;
  assign pb_d        = entry_i.bad ? 8'h00 : (entry_i.cbyte ^ ks_use[127-8*entry_i.pos -: 8]);

  always_comb begin
    ov_d = ov_q;
    if (pop_i && ov_q) begin
      ov_d = 1'b0;
    end
    if (go) begin
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      pb_q  <= pb_d;
      eom_q <= entry_i.fin;
      bad_q <= entry_i.bad;
    end
    if (ks_pop_o) begin
      cur_q <= ks_i;
    end
  end

  assign empty_o            = ~ov_q;
  assign plain_byte_o       = pb_q;
  assign end_of_message_o   = eom_q;
  assign bad_nonce_length_o = bad_q;
endmodule

// ----- rtl/ccm_star_ctr_decrypt_unit.sv -----
// CCM* counter-mode decryptor (no tag), one ciphertext byte per item.
// Each byte passes the byte queue and the result register; the first byte of a block
// also waits for its counter block to pass the request queue, AES unit and keystream
// queue. Throughput: one byte per cycle within a message while the queues have room
// and results are popped; the AES unit starts a new block only once the last has left.
// Reset (async, active low): queues empty, counter 1, position 0, nonce length 13.
module ccm_star_ctr_decrypt_unit
  import ccsd_pkg::*;
#(
  parameter int BYTE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  cipher_byte_i,
  input  logic        final_byte_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  plain_byte_o,
  output logic        end_of_message_o,
  output logic        bad_nonce_length_o,
  // register write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  logic [63:0]  key_high_q, key_low_q, nonce_lower_q;
  logic [39:0]  nonce_upper_q;
  logic [3:0]   nonce_bytes_q;

  ccsd_entry_t  entry_in, entry_out;
  logic         bq_full, bq_empty, bq_pop;
  logic         rq_push, rq_full, rq_empty, rq_pop;
  logic [127:0] rq_wdata, rq_rdata;
  logic         ks_push, ks_full, ks_empty, ks_pop;
  logic [127:0] ks_wdata, ks_rdata;
  logic         accept;

  // Hold off the producer when either the byte queue or the request queue is full.
  assign full        = bq_full | rq_full;
  assign accept      = push & ~full;
  assign cfg_ready_o = 1'b1;

  // Register file; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q    <= '0;
      key_low_q     <= '0;
      nonce_upper_q <= '0;
      nonce_lower_q <= '0;
      nonce_bytes_q <= NonceLenRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_KEY_HIGH:    key_high_q    <= cfg_data_i;
        REG_KEY_LOW:     key_low_q     <= cfg_data_i;
        REG_NONCE_UPPER: nonce_upper_q <= cfg_data_i[39:0];
        REG_NONCE_LOWER: nonce_lower_q <= cfg_data_i;
        REG_NONCE_LEN:   nonce_bytes_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Front: classify bytes and issue counter blocks.
  ccsd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .cipher_byte_i  (cipher_byte_i),
    .final_byte_i   (final_byte_i),
    .nonce_length_i (nonce_bytes_q),
    .nonce_upper_i  (nonce_upper_q),
    .nonce_lower_i  (nonce_lower_q),
    .entry_o        (entry_in),
    .req_push_o     (rq_push),
    .req_block_o    (rq_wdata)
  );

  // Byte queue decouples front and back.
  ccsd_fifo #(.WIDTH($bits(ccsd_entry_t)), .DEPTH(BYTE_DEPTH)) u_byte_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (entry_in),
    .pop_i   (bq_pop),
    .rdata_o (entry_out),
    .full_o  (bq_full),
    .empty_o (bq_empty)
  );

  // Counter block requests waiting for the AES unit.
  ccsd_fifo #(.WIDTH(128), .DEPTH(2)) u_req_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .wdata_i (rq_wdata),
    .pop_i   (rq_pop),
    .rdata_o (rq_rdata),
    .full_o  (rq_full),
    .empty_o (rq_empty)
  );

  ccsd_aes u_aes (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (~rq_empty),
    .in_ready_o  (rq_pop),
    .block_i     (rq_rdata),
    .key_i       ({key_high_q, key_low_q}),
    .out_valid_o (ks_push),
    .out_ready_i (~ks_full),
    .out_data_o  (ks_wdata)
  );

  // Finished keystream blocks.
  ccsd_fifo #(.WIDTH(128), .DEPTH(2)) u_ks_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ks_push),
    .wdata_i (ks_wdata),
    .pop_i   (ks_pop),
    .rdata_o (ks_rdata),
    .full_o  (ks_full),
    .empty_o (ks_empty)
  );

  // Back: combine bytes with keystream and present results.
  ccsd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .entry_i            (entry_out),
    .entry_empty_i      (bq_empty),
    .entry_pop_o        (bq_pop),
    .ks_i               (ks_rdata),
    .ks_empty_i         (ks_empty),
    .ks_pop_o           (ks_pop),
    .empty_o            (empty),
    .pop_i              (pop),
    .plain_byte_o       (plain_byte_o),
    .end_of_message_o   (end_of_message_o),
    .bad_nonce_length_o (bad_nonce_length_o)
  );
endmodule

// ----- rtl/ccsd_checker.sv -----
// Port-level checker for the decryptor, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module ccsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] plain_byte_o,
  input logic       end_of_message_o,
  input logic       bad_nonce_length_o,
  input logic       cfg_ready_o
);
  logic [9:0] result_w;

  assign result_w = {plain_byte_o, end_of_message_o, bad_nonce_length_o};

  // A bad nonce length always yields a zero byte.
  `CCSD_ASSERT(a_bad_zero, clk_i, rst_ni, (!empty && bad_nonce_length_o) |-> (plain_byte_o == '0))
  // A waiting result does not vanish.
  `CCSD_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop) |=> !empty)
  // A waiting result keeps its fields until taken.
  `CCSD_ASSERT(a_stable, clk_i, rst_ni, (!empty && !pop) |=> $stable(result_w))
  // Register writes are never stalled.
  `CCSD_ASSERT_ALWAYS(a_cfg_ready, clk_i, cfg_ready_o)
endmodule

bind ccm_star_ctr_decrypt_unit ccsd_checker u_ccsd_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench of the CCM* counter-mode decryptor (no tag).
// Drives byte requests and register writes, predicts each plain byte with an
// independent AES-128 model; depends on ccsd_pkg and ccm_star_ctr_decrypt_unit.
`timescale 1ns / 100ps

module testbench;
  import ccsd_pkg::*;

  // One predicted result of the decryptor.
  typedef struct {
    logic [7:0] plain;
    logic       eom;
    logic       bad;
  } plain_result_t;

  // Keeps its own copy of registers and counter state, predicts the plain byte
  // of each accepted request and checks results in order.
  class decrypt_scoreboard;
    logic [63:0]   key_hi, key_lo, nonce_lo, blk_ctr;
    logic [39:0]   nonce_hi;
    logic [3:0]    nonce_bytes, byte_pos;
    logic [7:0]    ks [16];
    plain_result_t pending_results[$];
    int            mismatches;
    int            checked;

    function void clear();
      key_hi = '0; key_lo = '0; nonce_hi = '0; nonce_lo = '0;
      nonce_bytes = NonceLenRst; blk_ctr = 64'd1; byte_pos = '0;
      foreach (ks[i]) ks[i] = 8'h00;
      pending_results.delete();
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(ccsd_reg_e idx, logic [63:0] data);
      case (idx)
        REG_KEY_HIGH:    key_hi = data;
        REG_KEY_LOW:     key_lo = data;
        REG_NONCE_UPPER: nonce_hi = data[39:0];
        REG_NONCE_LOWER: nonce_lo = data;
        REG_NONCE_LEN:   nonce_bytes = data[3:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] dbl(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // AES-128 encryption of one block, bytes in order 0..15.
    function void aes128(input logic [7:0] key[16], input logic [7:0] pt[16],
                         output logic [7:0] ct[16]);
      logic [7:0] w [176];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] rc, k0, k1, k2, k3, tmp, x, a0, a1, a2, a3;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) w[i] = key[i];
      for (int i = 16; i < 176; i += 4) begin
        k0 = w[i-4]; k1 = w[i-3]; k2 = w[i-2]; k3 = w[i-1];
        if (i % 16 == 0) begin
          tmp = k0;
          k0 = SBOX[k1] ^ rc; k1 = SBOX[k2]; k2 = SBOX[k3]; k3 = SBOX[tmp];
          rc = dbl(rc);
        end
        w[i] = w[i-16] ^ k0; w[i+1] = w[i-15] ^ k1;
        w[i+2] = w[i-14] ^ k2; w[i+3] = w[i-13] ^ k3;
      end
      for (int i = 0; i < 16; i++) s[i] = pt[i] ^ w[i];
      for (int r = 1; r <= 10; r++) begin
        // sub bytes and shift rows
        for (int i = 0; i < 16; i++)
          t[i] = SBOX[s[(i % 4) + 4 * (((i / 4) + (i % 4)) % 4)]];
        if (r < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            x = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ x ^ dbl(a0 ^ a1);
            t[4*c+1] = a1 ^ x ^ dbl(a1 ^ a2);
            t[4*c+2] = a2 ^ x ^ dbl(a2 ^ a3);
            t[4*c+3] = a3 ^ x ^ dbl(a3 ^ a0);
          end
        end
        for (int i = 0; i < 16; i++) s[i] = t[i] ^ w[16*r + i];
      end
      for (int i = 0; i < 16; i++) ct[i] = s[i];
    endfunction

    function logic [63:0] q_mask(logic [3:0] q);
      return (q >= 8) ? '1 : ((64'd1 << (8 * q)) - 64'd1);
    endfunction

    function void build_keystream(logic [3:0] q);
      logic [7:0]  key [16];
      logic [7:0]  blk [16];
      logic [7:0]  nonce [13];
      logic [63:0] ctr;
      ctr = blk_ctr & q_mask(q);
      for (int i = 0; i < 8; i++) begin
        key[i]     = key_hi[8*(7-i) +: 8];
        key[8 + i] = key_lo[8*(7-i) +: 8];
        nonce[5 + i] = nonce_lo[8*(7-i) +: 8];
      end
      for (int i = 0; i < 5; i++) nonce[i] = nonce_hi[8*(4-i) +: 8];
      foreach (blk[i]) blk[i] = 8'h00;
      blk[0] = 8'(q - 4'd1);
      for (int i = 0; i < nonce_bytes; i++) blk[1 + i] = nonce[i];
      for (int i = 0; i < q; i++) blk[15 - i] = ctr[8*i +: 8];
      aes128(key, blk, ks);
    endfunction

    // Note an accepted byte request and queue the result it causes.
    function void note_request(logic [7:0] cbyte, logic fin);
      plain_result_t r;
      logic [3:0]    q;
      r.eom = fin;
      if (nonce_bytes < NonceMin || nonce_bytes > NonceMax) begin
        r.plain = 8'h00;
        r.bad = 1'b1;
      end else begin
        q = BlockTop - nonce_bytes;
        if (byte_pos == 0) build_keystream(q);
        r.plain = cbyte ^ ks[byte_pos];
        r.bad = 1'b0;
        byte_pos = byte_pos + 4'd1;
        if (byte_pos == 0) blk_ctr = (blk_ctr + 64'd1) & q_mask(q);
      end
      if (fin) begin
        blk_ctr = 64'd1;
        byte_pos = '0;
      end
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] exp_v);
      $display("MISMATCH %0t: %s got %0h, expected %0h", $realtime, what, got, exp_v);
      mismatches++;
    endtask

    task check_result(logic [7:0] plain, logic eom, logic bad);
      plain_result_t e;
      checked++;
      if (pending_results.size() == 0) begin
        report("result with nothing pending", plain, 8'h00);
        return;
      end
      e = pending_results.pop_front();
      if (plain !== e.plain) report("plain_byte", plain, e.plain);
      if (eom !== e.eom) report("end_of_message", 8'(eom), 8'(e.eom));
      if (bad !== e.bad) report("bad_nonce_length", 8'(bad), 8'(e.bad));
    endtask
  endclass

  localparam int HoldOffCycles = 300;
  localparam int WatchdogLimit = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  cipher_byte_i = '0;
  logic        final_byte_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  plain_byte_o;
  logic        end_of_message_o;
  logic        bad_nonce_length_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  decrypt_scoreboard sb;
  int  idle_pct = 34;     // idling chance of both sides, in percent
  bit  hold_off = 1'b0;   // receiver holds off completely while set
  bit  stim_done = 1'b0;
  int  quiet_cycles = 0;
  int  bytes_sent = 0;
  int  bad_len_bytes = 0;

  always #10 clk_i = ~clk_i;

  ccm_star_ctr_decrypt_unit DUT (
    .clk_i, .rst_ni, .push, .full, .cipher_byte_i, .final_byte_i,
    .empty, .pop, .plain_byte_o, .end_of_message_o, .bad_nonce_length_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Write one register; hold the request until the channel takes it.
  task automatic write_reg(ccsd_reg_e idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one byte request, with a random gap first; hold until accepted.
  task automatic send_byte(logic [7:0] cbyte, logic fin);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    cipher_byte_i <= cbyte;
    final_byte_i <= fin;
    do @(posedge clk_i); while (full);
    sb.note_request(cbyte, fin);
    bytes_sent++;
    if (sb.nonce_bytes < NonceMin || sb.nonce_bytes > NonceMax) bad_len_bytes++;
    // push stays high into the next call; drop it only when nothing follows
  endtask

  task automatic stop_push();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  // Wait until every predicted result came back, then let the block settle.
  task automatic drain();
    stop_push();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  task automatic random_settings(logic [3:0] nlen);
    write_reg(REG_KEY_HIGH, {$urandom, $urandom});
    write_reg(REG_KEY_LOW, {$urandom, $urandom});
    write_reg(REG_NONCE_UPPER, {$urandom, $urandom});
    write_reg(REG_NONCE_LOWER, {$urandom, $urandom});
    write_reg(REG_NONCE_LEN, 64'(nlen));
  endtask

  // Receiver: pop at random, except during a hold-off stretch.
  always @(negedge clk_i) begin
    if (!rst_ni) pop <= 1'b0;
    else pop <= !hold_off && ($urandom_range(99) >= idle_pct);
  end

  // Check results and watch for a stuck block at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty)
        sb.check_result(plain_byte_o, end_of_message_o, bad_nonce_length_o);
      if ((pop && !empty) || (push && !full) || (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else if (!hold_off)
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no progress for %0d cycles", WatchdogLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    sb.clear();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings with zero key, then extreme register values.
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    drain();
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_NONCE_UPPER, '1);
    write_reg(REG_NONCE_LOWER, '1);
    write_reg(REG_NONCE_LEN, 64'(NonceMin));
    // a message crossing a block boundary, with a short last block
    send_message(19);
    drain();
    write_reg(REG_NONCE_LEN, 64'(NonceMax));
    send_message(17);
    drain();
    // bad lengths: below and above the valid range, final still restarts
    write_reg(REG_NONCE_LEN, 64'd0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b1);
    drain();
    write_reg(REG_NONCE_LEN, 64'd15);
    send_byte(8'hff, 1'b1);
    drain();
    // change the length mid-message: counter masking follows the new length
    write_reg(REG_NONCE_LEN, 64'd12);
    for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(255)), 1'b0);
    drain();
    write_reg(REG_NONCE_LEN, 64'(NonceMin));
    send_message(20);
    drain();

    // Random phases: mostly valid lengths, a few bad ones; short messages.
    for (int ph = 0; ph < 12; ph++) begin
      random_settings((ph % 6 == 5) ? 4'($urandom_range(6)) :
                      4'($urandom_range(NonceMax, NonceMin)));
      if (ph == 3) idle_pct = 0;    // a stretch with no idling at all
      if (ph == 4) idle_pct = 34;
      if (ph == 6) begin
        hold_off = 1'b1;            // fill the block while results stall
        fork
          begin
            repeat (HoldOffCycles) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      while (sb.checked + sb.pending_results.size() < 120 * (ph + 1) + 10)
        send_message(($urandom_range(9) == 0) ? $urandom_range(60, 33) :
                     $urandom_range(20, 1));
      drain();   // sender pauses until every result is back
    end

    stim_done = 1'b1;
    $display("Covered %0d byte requests, %0d under a bad nonce length, %0d results checked.",
             bytes_sent, bad_len_bytes, sb.checked);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- ccm_star_ctr_decrypt_unit.f -----
+incdir+rtl
rtl/ccsd_pkg.sv
rtl/ccsd_fifo.sv
rtl/ccsd_front.sv
rtl/ccsd_aes.sv
rtl/ccsd_back.sv
rtl/ccm_star_ctr_decrypt_unit.sv
rtl/ccsd_checker.sv
tb/testbench.sv
